FILE: hdl/assert_macros.svh
// Assertion macros used by the checker module of the slot allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/csa_pkg.sv
// Shared widths, request kinds and outcome codes of the cache slot allocator.
package csa_pkg;

    // Field widths of the request and result ports.
    localparam int KIND_W    = 3;
    localparam int TAG_W     = 48;
    localparam int SLOT_W    = 8;
    localparam int OWNER_W   = 12;
    localparam int OUTCOME_W = 2;
    localparam int CFG_W     = 9;
    localparam int VPTR_W    = 8;

    // Reset value of the active slot count.
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 9'd256;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_COMMIT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FREE    = 3'd4;

    // Result outcomes.
    localparam logic [OUTCOME_W-1:0] OUT_MATCH  = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_EMPTY  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_VICTIM = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_NONE   = 2'd3;

endpackage

FILE: hdl/csa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module csa_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/cache_slot_allocator_unit.sv
// Cache slot allocator: slot table in one RAM, round-robin victim search, command interface.
//
// A request is taken when start is high and busy is low; its single result appears on the
// o_ ports for one cycle with o_done, and the receiver must take it then. Commit with keep
// set, and every request that is rejected at once, answers in the cycle after acceptance.
// Commit without keep, release and free read their slot and answer from the S_ACCESS state.
// Lookup scans the active slots at one RAM read per cycle, n being the effective active
// slot count. Allocate runs one scan of n reads that looks for a matching tag and the first
// empty slot together; when neither is found it reduces the victim pointer modulo n by
// repeated subtraction in S_MOD and then scans again from there for a slot not in use. At
// 256 slots the pointer is already below n. The single read port of the slot RAM paces
// the scans. After reset the RAM is cleared one slot per cycle with busy high; configuration
// writes are taken at any time and must only be issued while the block is idle.
module cache_slot_allocator_unit #(
    parameter int SLOTS      = 256,
    parameter int OWNER_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel.
    input  logic                            start,
    output logic                            busy,
    input  logic [csa_pkg::KIND_W-1:0]      i_kind,
    input  logic [csa_pkg::TAG_W-1:0]       i_tag,
    input  logic [csa_pkg::SLOT_W-1:0]      i_slot_in,
    input  logic [csa_pkg::OWNER_W-1:0]     i_owner_in,
    input  logic                            i_keep,
    // Result channel.
    output logic                            o_done,
    output logic [csa_pkg::OUTCOME_W-1:0]   o_outcome,
    output logic [csa_pkg::SLOT_W-1:0]      o_slot_out,
    output logic [csa_pkg::OWNER_W-1:0]     o_prior_owner,
    output logic                            o_prior_owner_valid,
    // Configuration channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [csa_pkg::CFG_W-1:0]       i_cfg_data
);

    import csa_pkg::*;

    localparam int SB    = $clog2(SLOTS);
    localparam int CW    = (SB + 1 > CFG_W) ? SB + 1 : CFG_W;
    localparam int ENT_W = TAG_W + OWNER_BITS + 2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_A,
        S_MOD,
        S_SCAN_V,
        S_ACCESS
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [OUTCOME_W-1:0]   r_outcome, n_outcome;
    logic [SLOT_W-1:0]      r_slot_out, n_slot_out;
    logic [OWNER_W-1:0]     r_prior_owner, n_prior_owner;
    logic                   r_prior_valid, n_prior_valid;
    logic [CFG_W-1:0]       r_active;
    logic [VPTR_W-1:0]      r_vptr, n_vptr;
    logic [VPTR_W-1:0]      r_mod, n_mod;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [SB-1:0]          r_vidx, n_vidx;
    logic                   r_pend, n_pend;
    logic [SB-1:0]          r_pidx, n_pidx;
    logic                   r_have_empty, n_have_empty;
    logic [SB-1:0]          r_empty_idx, n_empty_idx;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [TAG_W-1:0]       r_tag, n_tag;
    logic [SB-1:0]          r_slot, n_slot;
    logic [OWNER_BITS-1:0]  r_owner, n_owner;

    // RAM ports.
    logic                   w_we;
    logic [SB-1:0]          w_waddr;
    logic [ENT_W-1:0]       w_wdata;
    logic                   w_re;
    logic [SB-1:0]          w_raddr;
    logic [ENT_W-1:0]       w_rdata;

    // Fields of the entry read last cycle.
    logic [TAG_W-1:0]       rd_tag;
    logic                   rd_use;
    logic [OWNER_BITS-1:0]  rd_owner;
    logic                   rd_known;
    logic                   rd_prior_valid;
    logic [OWNER_W-1:0]     rd_prior_owner;

    logic [CW-1:0]          eff_n;
    logic [CW-1:0]          slots_w;
    logic                   slot_ok;
    logic [OWNER_BITS-1:0]  in_owner;
    logic [CW-1:0]          p_next;
    logic [CW-1:0]          v_next;

    // Slot table: tag, in-use mark, owner and owner-known mark per slot.
    csa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_csa_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign rd_tag         = w_rdata[ENT_W-1 -: TAG_W];
    assign rd_use         = w_rdata[OWNER_BITS+1];
    assign rd_owner       = w_rdata[OWNER_BITS:1];
    assign rd_known       = w_rdata[0];
    assign rd_prior_valid = (rd_tag != '0) && rd_known;
    assign rd_prior_owner = rd_prior_valid ? OWNER_W'(rd_owner) : '0;

    // Effective slot count and request range check.
    assign slots_w  = CW'(SLOTS);
    assign eff_n    = (CW'(r_active) > slots_w) ? slots_w : CW'(r_active);
    assign slot_ok  = CW'(i_slot_in) < slots_w;
    assign in_owner = OWNER_BITS'(i_owner_in);
    assign p_next   = CW'(r_pidx) + CW'(1);
    assign v_next   = CW'(r_vidx) + CW'(1);

    // Next-state logic, RAM control and result selection.
    always_comb begin
        n_state       = r_state;
        n_done        = 1'b0;
        n_outcome     = r_outcome;
        n_slot_out    = r_slot_out;
        n_prior_owner = r_prior_owner;
        n_prior_valid = r_prior_valid;
        n_vptr        = r_vptr;
        n_mod         = r_mod;
        n_cnt         = r_cnt;
        n_vidx        = r_vidx;
        n_pend        = 1'b0;
        n_pidx        = r_pidx;
        n_have_empty  = r_have_empty;
        n_empty_idx   = r_empty_idx;
        n_kind        = r_kind;
        n_tag         = r_tag;
        n_slot        = r_slot;
        n_owner       = r_owner;
        w_we          = 1'b0;
        w_waddr       = '0;
        w_wdata       = '0;
        w_re          = 1'b0;
        w_raddr       = '0;

        case (r_state)
            // Sweep zeros through the table after reset.
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_cnt[SB-1:0];
                if (r_cnt == slots_w - CW'(1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end

            // Take a request and either answer at once or start its access.
            S_IDLE: begin
                if (start) begin
                    n_kind        = i_kind;
                    n_tag         = i_tag;
                    n_slot        = SB'(i_slot_in);
                    n_owner       = in_owner;
                    n_cnt         = '0;
                    n_have_empty  = 1'b0;
                    n_done        = 1'b1;
                    n_outcome     = OUT_NONE;
                    n_slot_out    = '0;
                    n_prior_owner = '0;
                    n_prior_valid = 1'b0;
                    case (i_kind)
                        KIND_ALLOC: begin
                            if (eff_n != '0) begin
                                n_done  = 1'b0;
                                n_state = S_SCAN_A;
                            end
                        end
                        KIND_LOOKUP: begin
                            if (eff_n != '0 && i_tag != '0) begin
                                n_done  = 1'b0;
                                n_state = S_SCAN_A;
                            end
                        end
                        KIND_COMMIT, KIND_RELEASE, KIND_FREE: begin
                            if (slot_ok) begin
                                if (i_kind == KIND_COMMIT && i_keep) begin
                                    w_we       = 1'b1;
                                    w_waddr    = SB'(i_slot_in);
                                    w_wdata    = {i_tag, 1'b1, in_owner, 1'b1};
                                    n_outcome  = OUT_MATCH;
                                    n_slot_out = i_slot_in;
                                end else begin
                                    w_re    = 1'b1;
                                    w_raddr = SB'(i_slot_in);
                                    n_done  = 1'b0;
                                    n_state = S_ACCESS;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // One read per cycle looking for a matching tag and the first empty slot.
            S_SCAN_A: begin
                if (r_cnt < eff_n) begin
                    w_re    = 1'b1;
                    w_raddr = r_cnt[SB-1:0];
                    n_pend  = 1'b1;
                    n_pidx  = r_cnt[SB-1:0];
                    n_cnt   = r_cnt + CW'(1);
                end
                if (r_pend) begin
                    if (rd_tag != '0 && rd_tag == r_tag) begin
                        // Tag hit: stop the scan and drop the read in flight.
                        n_pend     = 1'b0;
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                        n_outcome  = OUT_MATCH;
                        n_slot_out = SLOT_W'(r_pidx);
                        w_we       = 1'b1;
                        w_waddr    = r_pidx;
                        if (r_kind == KIND_ALLOC) begin
                            w_wdata       = '0;
                            n_prior_owner = rd_prior_owner;
                            n_prior_valid = rd_prior_valid;
                        end else begin
                            w_wdata       = {rd_tag, 1'b1, r_owner, 1'b1};
                            n_prior_owner = '0;
                            n_prior_valid = 1'b0;
                        end
                    end else if (rd_tag == '0 && !r_have_empty) begin
                        n_have_empty = 1'b1;
                        n_empty_idx  = r_pidx;
                    end
                end else if (r_cnt >= eff_n) begin
                    // Scan finished without a tag hit.
                    n_prior_owner = '0;
                    n_prior_valid = 1'b0;
                    if (r_kind == KIND_ALLOC && r_have_empty) begin
                        w_we       = 1'b1;
                        w_waddr    = r_empty_idx;
                        w_wdata    = '0;
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                        n_outcome  = OUT_EMPTY;
                        n_slot_out = SLOT_W'(r_empty_idx);
                    end else if (r_kind == KIND_ALLOC) begin
                        n_state = S_MOD;
                        n_mod   = r_vptr;
                    end else begin
                        n_state    = S_IDLE;
                        n_done     = 1'b1;
                        n_outcome  = OUT_NONE;
                        n_slot_out = '0;
                    end
                end
            end

            // Bring the victim pointer below the effective slot count.
            S_MOD: begin
                if (CW'(r_mod) >= eff_n) begin
                    n_mod = VPTR_W'(CW'(r_mod) - eff_n);
                end else begin
                    n_state = S_SCAN_V;
                    n_vidx  = SB'(r_mod);
                    n_cnt   = '0;
                end
            end

            // Rotating search for a slot that is not in use.
            S_SCAN_V: begin
                if (r_cnt < eff_n) begin
                    w_re    = 1'b1;
                    w_raddr = r_vidx;
                    n_pend  = 1'b1;
                    n_pidx  = r_vidx;
                    n_cnt   = r_cnt + CW'(1);
                    n_vidx  = (v_next == eff_n) ? '0 : SB'(v_next);
                end
                if (r_pend) begin
                    if (!rd_use) begin
                        n_pend        = 1'b0;
                        n_state       = S_IDLE;
                        n_done        = 1'b1;
                        n_outcome     = OUT_VICTIM;
                        n_slot_out    = SLOT_W'(r_pidx);
                        n_prior_owner = rd_prior_owner;
                        n_prior_valid = rd_prior_valid;
                        n_vptr        = (p_next == eff_n) ? '0 : VPTR_W'(p_next);
                        w_we          = 1'b1;
                        w_waddr       = r_pidx;
                        w_wdata       = '0;
                    end
                end else if (r_cnt >= eff_n) begin
                    // Every active slot is tagged and in use.
                    n_state       = S_IDLE;
                    n_done        = 1'b1;
                    n_outcome     = OUT_NONE;
                    n_slot_out    = '0;
                    n_prior_owner = '0;
                    n_prior_valid = 1'b0;
                end
            end

            // Read-modify-write of one addressed slot.
            S_ACCESS: begin
                n_state       = S_IDLE;
                n_done        = 1'b1;
                n_outcome     = OUT_MATCH;
                n_slot_out    = SLOT_W'(r_slot);
                n_prior_owner = '0;
                n_prior_valid = 1'b0;
                w_we          = 1'b1;
                w_waddr       = r_slot;
                case (r_kind)
                    KIND_COMMIT: begin
                        w_wdata = {r_tag, rd_use, rd_owner, rd_known};
                    end
                    KIND_RELEASE: begin
                        w_wdata = {rd_tag, 1'b0, rd_owner, rd_known};
                    end
                    default: begin
                        w_wdata       = '0;
                        n_prior_owner = rd_prior_owner;
                        n_prior_valid = rd_prior_valid;
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_busy = (n_state != S_IDLE);
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_busy       <= 1'b1;
            r_done       <= 1'b0;
            r_vptr       <= '0;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_have_empty <= 1'b0;
            r_active     <= ACTIVE_RESET;
        end else begin
            r_state      <= n_state;
            r_busy       <= n_busy;
            r_done       <= n_done;
            r_vptr       <= n_vptr;
            r_cnt        <= n_cnt;
            r_pend       <= n_pend;
            r_have_empty <= n_have_empty;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
        end
        r_outcome     <= n_outcome;
        r_slot_out    <= n_slot_out;
        r_prior_owner <= n_prior_owner;
        r_prior_valid <= n_prior_valid;
        r_mod         <= n_mod;
        r_vidx        <= n_vidx;
        r_pidx        <= n_pidx;
        r_empty_idx   <= n_empty_idx;
        r_kind        <= n_kind;
        r_tag         <= n_tag;
        r_slot        <= n_slot;
        r_owner       <= n_owner;
    end

    assign busy                = r_busy;
    assign o_done              = r_done;
    assign o_outcome           = r_outcome;
    assign o_slot_out          = r_slot_out;
    assign o_prior_owner       = r_prior_owner;
    assign o_prior_owner_valid = r_prior_valid;
    assign o_cfg_ready         = 1'b1;

endmodule

FILE: hdl/csa_checker.sv
// Port-level checker of the cache slot allocator and its bind to the top level.
`include "assert_macros.svh"

module csa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_done,
    input logic [csa_pkg::OUTCOME_W-1:0]   o_outcome,
    input logic [csa_pkg::SLOT_W-1:0]      o_slot_out,
    input logic                            o_prior_owner_valid
);

    import csa_pkg::*;

    // An accepted request either answers next cycle or keeps the block busy.
    `CSA_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done, "accepted request neither answered nor busy")

    // A result is shown only once the block is free for the next request.
    `CSA_ASSERT_IMPLY(a_done_not_busy, i_clk, i_rst_n, o_done, !busy, "result shown while busy")

    // A miss or rejection carries no slot and no prior owner.
    `CSA_ASSERT_IMPLY(a_none_clean, i_clk, i_rst_n, o_done && o_outcome == OUT_NONE, o_slot_out == '0 && !o_prior_owner_valid, "miss result carries data")

    // Only a freed tagged slot reports an owner, never an empty-slot pick.
    `CSA_ASSERT_IMPLY(a_prior_kind, i_clk, i_rst_n, o_done && o_prior_owner_valid, o_outcome == OUT_MATCH || o_outcome == OUT_VICTIM, "prior owner on wrong outcome")

endmodule

bind cache_slot_allocator_unit csa_checker u_csa_checker (.*);
